FILE: rtl/core/q_style_byte_escaper_unit_defines.svh
// Assertion macros for the Q-style byte escaper.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef Q_STYLE_BYTE_ESCAPER_UNIT_DEFINES_SVH
`define Q_STYLE_BYTE_ESCAPER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define QBE_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qbe assertion failed");
`define QBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qbe assertion failed");
`else
`define QBE_ASSERT_IMPLIES(lbl, ante, cons)
`define QBE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/qbe_pkg.sv
`timescale 1ns / 1ps
package qbe_pkg;

  localparam int MAX_CAPACITY = 4096;
  localparam int MIN_CAPACITY = 2;
  localparam int CAP_W = 13;
  localparam int CNT_W = 12;
  localparam int MAX_RESULTS = 4;
  localparam int RES_CNT_W = 3;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 13'd256;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       trunc;
  } res_item_t;

  typedef struct packed {
    res_item_t [MAX_RESULTS-1:0] items;
    logic [RES_CNT_W-1:0]        count;
    logic [CNT_W-1:0]            next_count;
    logic                        next_closed;
  } enc_out_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      return CH_ZERO + {4'd0, v};
    end else begin
      return CH_UPPER_A + {4'd0, v - 4'd10};
    end
  endfunction

endpackage

FILE: rtl/core/qbe_encode.sv
`timescale 1ns / 1ps
module qbe_encode
  import qbe_pkg::*;
(
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic [CNT_W-1:0] written_count,
  input  logic             record_closed,
  input  logic [CAP_W-1:0] capacity,
  output enc_out_t         enc
);

  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] count_ext;
  logic [CAP_W-1:0] new_count;
  logic             escape;

  always_comb begin
    if (capacity < CAP_W'(MIN_CAPACITY)) begin
      cap = CAP_W'(MIN_CAPACITY);
    end else if (capacity > CAP_W'(MAX_CAPACITY)) begin
      cap = CAP_W'(MAX_CAPACITY);
    end else begin
      cap = capacity;
    end
  end

  assign count_ext = {1'b0, written_count};
  assign escape = (in_byte == CH_UNDERSCORE) || (in_byte == CH_EQUALS) ||
                  (in_byte < CH_SPACE) || (in_byte >= CH_DEL);

  always_comb begin
    enc = '0;
    enc.next_count = written_count;
    enc.next_closed = record_closed;
    new_count = count_ext;
    if (record_closed) begin
      if (in_last) begin
        enc.next_count = '0;
        enc.next_closed = 1'b0;
      end
    end else if (in_byte == CH_NUL) begin
      enc.items[0] = '{ch: CH_NUL, last: 1'b1, trunc: 1'b0};
      enc.count = RES_CNT_W'(1);
      enc.next_count = '0;
      enc.next_closed = !in_last;
    end else if (escape && (count_ext + CAP_W'(3) >= cap)) begin
      enc.items[0] = '{ch: CH_NUL, last: 1'b1, trunc: 1'b1};
      enc.count = RES_CNT_W'(1);
      enc.next_count = '0;
      enc.next_closed = !in_last;
    end else begin
      if (in_byte == CH_SPACE) begin
        enc.items[0] = '{ch: CH_UNDERSCORE, last: 1'b0, trunc: 1'b0};
        enc.count = RES_CNT_W'(1);
        new_count = count_ext + CAP_W'(1);
      end else if (escape) begin
        enc.items[0] = '{ch: CH_EQUALS, last: 1'b0, trunc: 1'b0};
        enc.items[1] = '{ch: hex_digit(in_byte[7:4]), last: 1'b0, trunc: 1'b0};
        enc.items[2] = '{ch: hex_digit(in_byte[3:0]), last: 1'b0, trunc: 1'b0};
        enc.count = RES_CNT_W'(3);
        new_count = count_ext + CAP_W'(3);
      end else begin
        enc.items[0] = '{ch: in_byte, last: 1'b0, trunc: 1'b0};
        enc.count = RES_CNT_W'(1);
        new_count = count_ext + CAP_W'(1);
      end
      if (new_count >= cap - CAP_W'(1)) begin
        enc.items[enc.count[1:0]] = '{ch: CH_NUL, last: 1'b1, trunc: 1'b1};
        enc.count = enc.count + RES_CNT_W'(1);
        enc.next_count = '0;
        enc.next_closed = !in_last;
      end else if (in_last) begin
        enc.items[enc.count[1:0]] = '{ch: CH_NUL, last: 1'b1, trunc: 1'b0};
        enc.count = enc.count + RES_CNT_W'(1);
        enc.next_count = '0;
        enc.next_closed = 1'b0;
      end else begin
        enc.next_count = new_count[CNT_W-1:0];
      end
    end
  end

endmodule

FILE: rtl/core/q_style_byte_escaper_unit.sv
`timescale 1ns / 1ps
// Q-style byte escaper. Source bytes arrive on the input channel (in_valid,
// in_stall, in_byte, in_last) and escaped characters leave on the output
// channel (out_valid, out_stall, out_char, out_last, truncated), one character
// per request. A record ends with a NUL character that has out_last set and
// carries the truncated flag. The output capacity is written through
// cfg_valid, cfg_ready and out_capacity, by the user only while the block is
// idle; the block itself does not enforce this. cfg_ready is always high.
// A byte accepted at one clock edge has its first character, if it yields
// any, on the output in the cycle after. Each byte yields zero to four
// characters, and the next byte is taken in the cycle the last character of
// the previous one leaves, so the block accepts a new byte only once it is
// through with the last one. The four-entry result buffer drains one
// character per cycle while out_stall is low.
// Reset sets the capacity to 256 and clears the character count, the closed
// state and the count of buffered characters. While the receiver stalls, the
// current character holds and in_stall stays high while any character is left.
// Without a stall, in_stall is high while more than one character is left.
`include "q_style_byte_escaper_unit_defines.svh"
module q_style_byte_escaper_unit
  import qbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_char,
  output logic             out_last,
  output logic             truncated,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] out_capacity
);

  logic [CAP_W-1:0]            capacity;
  logic [CNT_W-1:0]            written_count;
  logic                        record_closed;
  res_item_t [MAX_RESULTS-1:0] res_buf;
  logic [RES_CNT_W-1:0]        remaining;
  enc_out_t                    enc;
  logic                        in_take;
  logic                        out_take;

  qbe_encode u_encode (
    .in_byte       (in_byte),
    .in_last       (in_last),
    .written_count (written_count),
    .record_closed (record_closed),
    .capacity      (capacity),
    .enc           (enc)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = (remaining != '0);
  assign out_take = out_valid && !out_stall;
  assign in_stall = !((remaining == '0) ||
                      ((remaining == RES_CNT_W'(1)) && !out_stall));
  assign in_take = in_valid && !in_stall;

  assign out_char = res_buf[0].ch;
  assign out_last = res_buf[0].last;
  assign truncated = res_buf[0].trunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= out_capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written_count <= '0;
      record_closed <= 1'b0;
    end else if (in_take) begin
      written_count <= enc.next_count;
      record_closed <= enc.next_closed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (in_take) begin
      remaining <= enc.count;
    end else if (out_take) begin
      remaining <= remaining - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_buf <= enc.items;
    end else if (out_take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res_buf[i] <= res_buf[i+1];
      end
    end
  end

  `QBE_ASSERT_IMPLIES(a_no_overwrite, in_take && (remaining != '0), (remaining == RES_CNT_W'(1)) && !out_stall)
  `QBE_ASSERT_IMPLIES(a_term_is_nul, out_valid && out_last, out_char == CH_NUL)
  `QBE_ASSERT_IMPLIES(a_trunc_only_on_term, out_valid && !out_last, !truncated)
  `QBE_ASSERT_NEXT(a_closed_discards, in_take && record_closed, remaining == '0)

endmodule
